[sv/sgi_pkg.sv]
// Shared types and constants for the segment intersection block.
// No dependencies; imported by the queue, the front and back ends and the top level.
`default_nettype none

package sgi_pkg;

  // Entries of the queue between the classify front end and the point back end
  localparam int FIFO_DEPTH = 4;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

[sv/sgi_if.sv]
// Request channels of the segment intersection block: segment pairs in, crossings out.
// Depends on nothing; the width parameter follows the coordinate width of the top level.
`default_nettype none

interface sgi_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sgi_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic                crosses;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;

  modport source (output valid, crosses, cross_x, cross_y, input ready);
  modport sink   (input valid, crosses, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

[sv/sgi_fifo.sv]
// Short queue that decouples the classify front end from the point back end.
// Depends on sgi_pkg for the depth and the status struct.
`default_nettype none

module sgi_fifo
  import sgi_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output fifo_stat_t    stat
);

  localparam int AW = $clog2(FIFO_DEPTH);

  logic [DW-1:0] mem_r [FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  // Update pointers and fill count
  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = pop  ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == (AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (AW+1)'(1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

[sv/sgi_front.sv]
// Front end: accept segment pairs, test bounding boxes and cross-product signs,
// and hand the division operands to the queue. Depends on sgi_pkg and sgi_if.
`default_nettype none

module sgi_front
  import sgi_pkg::*;
#(
  parameter int CW = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  sgi_in_if.sink              in_ch,
  input  fifo_stat_t          stat,
  output logic                push,
  output logic                hit,
  output logic signed [CW-1:0] ax0,
  output logic signed [CW-1:0] ay0,
  output logic [CW-1:0]       mx,
  output logic [CW-1:0]       my,
  output logic                negx,
  output logic                negy,
  output logic [2*CW:0]       d1m,
  output logic [2*CW+1:0]     aden
);

  localparam int DW = CW + 1;      // coordinate difference
  localparam int PW = 2 * CW + 2;  // product and cross product
  localparam int NW = 2 * CW + 3;  // denominator

  logic en;

  // Stage 1: differences and box test
  logic signed [DW-1:0] ux_c, uy_c, vx_c, vy_c;
  logic signed [DW-1:0] wx0_c, wy0_c, wx1_c, wy1_c, px0_c, py0_c, px1_c, py1_c;
  logic                 box_c;
  logic signed [CW-1:0] lo_ax, hi_ax, lo_ay, hi_ay, lo_bx, hi_bx, lo_by, hi_by;

  logic                 v1_r, box1_r;
  logic signed [CW-1:0] ax1_r, ay1_r;
  logic signed [DW-1:0] ux1_r, uy1_r, vx1_r, vy1_r;
  logic signed [DW-1:0] wx0_r, wy0_r, wx1_r, wy1_r, px0_r, py0_r, px1_r, py1_r;

  // Stage 2: products
  logic                 v2_r, box2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  logic signed [DW-1:0] ux2_r, uy2_r;
  logic signed [PW-1:0] e1a_r, e1b_r, e2a_r, e2b_r, d1a_r, d1b_r, d2a_r, d2b_r;

  // Stage 3: cross products and crossing decision
  logic signed [PW-1:0] e1_c, e2_c, d1_c, d2_c;
  logic                 hit_c;
  logic                 v3_r, hit3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  logic signed [DW-1:0] ux3_r, uy3_r;
  logic signed [PW-1:0] d13_r, d23_r;

  logic signed [NW-1:0] den_c, aden_c;
  logic signed [PW-1:0] d1abs_c;
  logic signed [DW-1:0] uxabs_c, uyabs_c;

  // Advance whenever the queue has room
  assign en          = !stat.full;
  assign in_ch.ready = en;

  always_comb begin
    ux_c  = $signed({in_ch.a_end_x[CW-1], in_ch.a_end_x})
          - $signed({in_ch.a_start_x[CW-1], in_ch.a_start_x});
    uy_c  = $signed({in_ch.a_end_y[CW-1], in_ch.a_end_y})
          - $signed({in_ch.a_start_y[CW-1], in_ch.a_start_y});
    vx_c  = $signed({in_ch.b_end_x[CW-1], in_ch.b_end_x})
          - $signed({in_ch.b_start_x[CW-1], in_ch.b_start_x});
    vy_c  = $signed({in_ch.b_end_y[CW-1], in_ch.b_end_y})
          - $signed({in_ch.b_start_y[CW-1], in_ch.b_start_y});
    wx0_c = $signed({in_ch.b_start_x[CW-1], in_ch.b_start_x})
          - $signed({in_ch.a_start_x[CW-1], in_ch.a_start_x});
    wy0_c = $signed({in_ch.b_start_y[CW-1], in_ch.b_start_y})
          - $signed({in_ch.a_start_y[CW-1], in_ch.a_start_y});
    wx1_c = $signed({in_ch.b_end_x[CW-1], in_ch.b_end_x})
          - $signed({in_ch.a_start_x[CW-1], in_ch.a_start_x});
    wy1_c = $signed({in_ch.b_end_y[CW-1], in_ch.b_end_y})
          - $signed({in_ch.a_start_y[CW-1], in_ch.a_start_y});
    px0_c = -wx0_c;
    py0_c = -wy0_c;
    px1_c = $signed({in_ch.a_end_x[CW-1], in_ch.a_end_x})
          - $signed({in_ch.b_start_x[CW-1], in_ch.b_start_x});
    py1_c = $signed({in_ch.a_end_y[CW-1], in_ch.a_end_y})
          - $signed({in_ch.b_start_y[CW-1], in_ch.b_start_y});

    lo_ax = (in_ch.a_start_x < in_ch.a_end_x) ? in_ch.a_start_x : in_ch.a_end_x;
    hi_ax = (in_ch.a_start_x > in_ch.a_end_x) ? in_ch.a_start_x : in_ch.a_end_x;
    lo_ay = (in_ch.a_start_y < in_ch.a_end_y) ? in_ch.a_start_y : in_ch.a_end_y;
    hi_ay = (in_ch.a_start_y > in_ch.a_end_y) ? in_ch.a_start_y : in_ch.a_end_y;
    lo_bx = (in_ch.b_start_x < in_ch.b_end_x) ? in_ch.b_start_x : in_ch.b_end_x;
    hi_bx = (in_ch.b_start_x > in_ch.b_end_x) ? in_ch.b_start_x : in_ch.b_end_x;
    lo_by = (in_ch.b_start_y < in_ch.b_end_y) ? in_ch.b_start_y : in_ch.b_end_y;
    hi_by = (in_ch.b_start_y > in_ch.b_end_y) ? in_ch.b_start_y : in_ch.b_end_y;
    box_c = (lo_ax <= hi_bx) && (hi_ax >= lo_bx) && (lo_ay <= hi_by) && (hi_ay >= lo_by);
  end

  // Cross products and the strict opposite-side test
  always_comb begin
    e1_c  = e1a_r - e1b_r;
    e2_c  = e2a_r - e2b_r;
    d1_c  = d1a_r - d1b_r;
    d2_c  = d2a_r - d2b_r;
    hit_c = box2_r
         && (e1_c != '0) && (e2_c != '0) && (e1_c[PW-1] != e2_c[PW-1])
         && (d1_c != '0) && (d2_c != '0) && (d1_c[PW-1] != d2_c[PW-1]);
  end

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload of the stages
  always_ff @(posedge clk) begin
    if (en) begin
      box1_r <= box_c;
      ax1_r  <= in_ch.a_start_x;
      ay1_r  <= in_ch.a_start_y;
      ux1_r  <= ux_c;
      uy1_r  <= uy_c;
      vx1_r  <= vx_c;
      vy1_r  <= vy_c;
      wx0_r  <= wx0_c;
      wy0_r  <= wy0_c;
      wx1_r  <= wx1_c;
      wy1_r  <= wy1_c;
      px0_r  <= px0_c;
      py0_r  <= py0_c;
      px1_r  <= px1_c;
      py1_r  <= py1_c;

      box2_r <= box1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      e1a_r  <= ux1_r * wy0_r;
      e1b_r  <= uy1_r * wx0_r;
      e2a_r  <= ux1_r * wy1_r;
      e2b_r  <= uy1_r * wx1_r;
      d1a_r  <= vx1_r * py0_r;
      d1b_r  <= vy1_r * px0_r;
      d2a_r  <= vx1_r * py1_r;
      d2b_r  <= vy1_r * px1_r;

      hit3_r <= hit_c;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      ux3_r  <= ux2_r;
      uy3_r  <= uy2_r;
      d13_r  <= d1_c;
      d23_r  <= d2_c;
    end
  end

  // Division operands for the queue
  always_comb begin
    den_c   = $signed({d13_r[PW-1], d13_r}) - $signed({d23_r[PW-1], d23_r});
    aden_c  = den_c[NW-1] ? -den_c : den_c;
    d1abs_c = d13_r[PW-1] ? -d13_r : d13_r;
    uxabs_c = ux3_r[DW-1] ? -ux3_r : ux3_r;
    uyabs_c = uy3_r[DW-1] ? -uy3_r : uy3_r;
  end

  assign push = en && v3_r;
  assign hit  = hit3_r;
  assign ax0  = ax3_r;
  assign ay0  = ay3_r;
  assign mx   = uxabs_c[CW-1:0];
  assign my   = uyabs_c[CW-1:0];
  assign negx = ux3_r[DW-1] ^ (d13_r[PW-1] ^ den_c[NW-1]);
  assign negy = uy3_r[DW-1] ^ (d13_r[PW-1] ^ den_c[NW-1]);
  assign d1m  = d1abs_c[2*CW:0];
  assign aden = aden_c[2*CW+1:0];

endmodule

`default_nettype wire

[sv/sgi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, stalled by a shared enable.
// No dependencies; used twice by the back end, one lane per coordinate.
`default_nettype none

module sgi_div #(
  parameter int CW = 24
) (
  input  logic              clk,
  input  logic              en,
  input  logic [3*CW+2:0]   num,
  input  logic [2*CW+2:0]   dv,
  output logic [CW-1:0]     quo
);

  localparam int RW = 2 * CW + 3;  // remainder and divisor

  logic [RW-1:0] rem_r [CW+1];
  logic [RW-1:0] dv_r  [CW+1];
  logic [CW-1:0] low_r [CW+1];
  logic [CW-1:0] quo_r [CW+1];

  // Load the top of the dividend, which is already below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[3*CW+2:CW];
      low_r[0] <= num[CW-1:0];
      dv_r[0]  <= dv;
      quo_r[0] <= '0;
    end
  end

  // One trial subtraction per stage
  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    assign trial = {rem_r[k], low_r[k][CW-1]};
    assign diff  = trial - {1'b0, dv_r[k]};
    assign ge    = (trial >= {1'b0, dv_r[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[RW-1:0] : trial[RW-1:0];
        low_r[k+1] <= {low_r[k][CW-2:0], 1'b0};
        dv_r[k+1]  <= dv_r[k];
        quo_r[k+1] <= {quo_r[k][CW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[CW];

endmodule

`default_nettype wire

[sv/sgi_back.sv]
// Back end: form the rounded ratio numerators, divide, and place the point on segment A.
// Depends on sgi_pkg, sgi_if and sgi_div.
`default_nettype none

module sgi_back
  import sgi_pkg::*;
#(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sgi_out_if.source            out_ch,
  input  fifo_stat_t           stat,
  output logic                 pop,
  input  logic                 hit,
  input  logic signed [CW-1:0] ax0,
  input  logic signed [CW-1:0] ay0,
  input  logic [CW-1:0]        mx,
  input  logic [CW-1:0]        my,
  input  logic                 negx,
  input  logic                 negy,
  input  logic [2*CW:0]        d1m,
  input  logic [2*CW+1:0]      aden
);

  localparam int SL = CW + 2;      // side line length, matches product stage plus divider
  localparam int MW = 3 * CW + 1;  // numerator
  localparam int NW = 3 * CW + 3;  // doubled numerator plus denominator

  logic en;

  // Side line carried alongside the dividers
  logic                 sv_r   [SL];
  logic                 shit_r [SL];
  logic signed [CW-1:0] sx_r   [SL];
  logic signed [CW-1:0] sy_r   [SL];
  logic                 snx_r  [SL];
  logic                 sny_r  [SL];

  // Partial products of the numerators
  logic [2*CW:0]   pxl_r, pyl_r;
  logic [2*CW-1:0] pxh_r, pyh_r;
  logic [2*CW+1:0] aden_r;
  logic [MW-1:0]   numx_c, numy_c;
  logic [NW-1:0]   n2x_c, n2y_c;
  logic [2*CW+2:0] dv_c;
  logic [CW-1:0]   qx, qy;

  logic signed [CW:0] resx_c, resy_c;
  logic               ov_r, oc_r;
  logic [CW-1:0]      ox_r, oy_r;

  // Advance when the output register is free or being taken
  assign en  = !ov_r || out_ch.ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SL; i++) begin
        sv_r[i] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= pop;
      for (int i = 1; i < SL; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
      ov_r <= sv_r[SL-1];
    end
  end

  // Hold side data and split the products over the halves of |d1|
  always_ff @(posedge clk) begin
    if (en) begin
      shit_r[0] <= hit;
      sx_r[0]   <= ax0;
      sy_r[0]   <= ay0;
      snx_r[0]  <= negx;
      sny_r[0]  <= negy;
      for (int i = 1; i < SL; i++) begin
        shit_r[i] <= shit_r[i-1];
        sx_r[i]   <= sx_r[i-1];
        sy_r[i]   <= sy_r[i-1];
        snx_r[i]  <= snx_r[i-1];
        sny_r[i]  <= sny_r[i-1];
      end
      pxl_r  <= d1m[CW:0] * mx;
      pyl_r  <= d1m[CW:0] * my;
      pxh_r  <= d1m[2*CW:CW+1] * mx;
      pyh_r  <= d1m[2*CW:CW+1] * my;
      aden_r <= aden;
    end
  end

  // Round to nearest: (2 * num + den) / (2 * den)
  always_comb begin
    numx_c = (MW'(pxh_r) << (CW + 1)) + MW'(pxl_r);
    numy_c = (MW'(pyh_r) << (CW + 1)) + MW'(pyl_r);
    n2x_c  = NW'({numx_c, 1'b0}) + NW'(aden_r);
    n2y_c  = NW'({numy_c, 1'b0}) + NW'(aden_r);
    dv_c   = {aden_r, 1'b0};
  end

  sgi_div #(.CW(CW)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (n2x_c),
    .dv  (dv_c),
    .quo (qx)
  );

  sgi_div #(.CW(CW)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (n2y_c),
    .dv  (dv_c),
    .quo (qy)
  );

  // Offset from the start point; drop the point when there is no crossing
  always_comb begin
    resx_c = $signed({sx_r[SL-1][CW-1], sx_r[SL-1]})
           + (snx_r[SL-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
    resy_c = $signed({sy_r[SL-1][CW-1], sy_r[SL-1]})
           + (sny_r[SL-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r <= shit_r[SL-1];
      ox_r <= shit_r[SL-1] ? resx_c[CW-1:0] : '0;
      oy_r <= shit_r[SL-1] ? resy_c[CW-1:0] : '0;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.crosses = oc_r;
  assign out_ch.cross_x = ox_r;
  assign out_ch.cross_y = oy_r;

endmodule

`default_nettype wire

[sv/segment_intersection_2d.sv]
// Throughput: one request per cycle unless the queue is full or the output is held back;
// the divider has one stage per quotient bit.
// Front end (3 stages) and back end are parted by a 4-entry queue; each stalls on its own.
// Reset: synchronous active-low rst_n clears all valid bits and the queue; no clearing pass.
// Depends on sgi_pkg, sgi_if, sgi_fifo, sgi_front, sgi_div and sgi_back.
`default_nettype none

module segment_intersection_2d
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  sgi_in_if.sink      in_ch,
  sgi_out_if.source   out_ch
);

  localparam int CW = COORD_BITS;
  localparam int EW = 8 * CW + 6;

  fifo_stat_t           stat;
  logic                 push, pop;
  logic [EW-1:0]        wdata, rdata;

  logic                 f_hit, f_negx, f_negy;
  logic signed [CW-1:0] f_ax0, f_ay0;
  logic [CW-1:0]        f_mx, f_my;
  logic [2*CW:0]        f_d1m;
  logic [2*CW+1:0]      f_aden;

  sgi_front #(.CW(CW)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .push  (push),
    .hit   (f_hit),
    .ax0   (f_ax0),
    .ay0   (f_ay0),
    .mx    (f_mx),
    .my    (f_my),
    .negx  (f_negx),
    .negy  (f_negy),
    .d1m   (f_d1m),
    .aden  (f_aden)
  );

  // Pack a queue entry
  assign wdata = {f_hit, f_ax0, f_ay0, f_mx, f_my, f_negx, f_negy, f_d1m, f_aden};

  sgi_fifo #(.DW(EW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (stat)
  );

  sgi_back #(.CW(CW)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .out_ch (out_ch),
    .stat   (stat),
    .pop    (pop),
    .hit    (rdata[EW-1]),
    .ax0    (rdata[EW-2 -: CW]),
    .ay0    (rdata[EW-2-CW -: CW]),
    .mx     (rdata[EW-2-2*CW -: CW]),
    .my     (rdata[EW-2-3*CW -: CW]),
    .negx   (rdata[4*CW+4]),
    .negy   (rdata[4*CW+3]),
    .d1m    (rdata[4*CW+2 -: 2*CW+1]),
    .aden   (rdata[2*CW+1:0])
  );

endmodule

`default_nettype wire
